>>> sv/nearest_segment_hit_test_unit_assert.svh
// Assertion macros for the hit test unit checker.
`ifndef NEAREST_SEGMENT_HIT_TEST_UNIT_ASSERT_SVH
`define NEAREST_SEGMENT_HIT_TEST_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define NSHT_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define NSHT_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> sv/nsht_pkg.sv
// ---------------------------------------------------------------------------
// nsht_pkg
// Types and constants shared by the nearest segment hit test unit.
// ---------------------------------------------------------------------------
`default_nettype none
package nsht_pkg;
   localparam int IdWidth    = 16;

   localparam logic [1:0] ACT_BEGIN    = 2'd0;
   localparam logic [1:0] ACT_CIRCLE   = 2'd1;
   localparam logic [1:0] ACT_SEGMENT  = 2'd2;
   localparam logic [1:0] ACT_RESERVED = 2'd3;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_CIRCLE = 2'd1;
   localparam logic [1:0] KIND_LINE   = 2'd2;

   localparam logic [1:0] REG_THRESHOLD = 2'd0;

   typedef struct packed {
      logic [1:0]             action;
      logic signed [15:0]     first_x;
      logic signed [15:0]     first_y;
      logic signed [15:0]     second_x;
      logic signed [15:0]     second_y;
      logic [15:0]            radius;
      logic [15:0]            entity_id;
      logic                   last;
   } req_type;

   typedef struct packed {
      logic [1:0]  hit_kind;
      logic [15:0] picked_id;
      logic [34:0] picked_distance_sq;
   } rsp_type;
endpackage
`default_nettype wire

>>> sv/nsht_queue.sv
// ---------------------------------------------------------------------------
// nsht_queue
// Two-entry queue between the front end and the distance engine.
// ---------------------------------------------------------------------------
`default_nettype none
module nsht_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  nsht_pkg::req_type     push_data,
   output logic                  full,
   output logic                  empty,
   input  wire logic             pop,
   output nsht_pkg::req_type     pop_data
);
   import nsht_pkg::*;

   req_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full     = count_ff[1];
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];
endmodule
`default_nettype wire

>>> sv/nsht_engine.sv
// ---------------------------------------------------------------------------
// nsht_engine
// Back end: distance math, long division and best-candidate tracking.
// ---------------------------------------------------------------------------
`default_nettype none
module nsht_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  nsht_pkg::req_type     in_data,
   output logic                  in_pop,
   input  wire logic [31:0]      threshold,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output nsht_pkg::rsp_type     rsp_data
);
   import nsht_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PROD  = 6'b000010,
      ST_CLASS = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_UPD   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   req_type   item_ff, item_in;
   logic signed [15:0] qx_ff, qx_in, qy_ff, qy_in;
   logic circle_ff, circle_in, line_ff, line_in;
   logic [IdWidth-1:0] best_id_ff, best_id_in;
   logic [34:0] best_d_ff, best_d_in;
   // products
   logic signed [16:0] dx_ff, dy_ff, ex_ff, ey_ff, wx_ff, wy_ff;
   logic signed [16:0] dx_in, dy_in, ex_in, ey_in, wx_in, wy_in;
   logic signed [35:0] dsq_ff, dsq_in, wsq_ff, wsq_in, l2_ff, l2_in;
   logic signed [35:0] dot_ff, dot_in, cr_ff, cr_in;
   logic [31:0] rsq_ff, rsq_in;
   logic [1:0]  phase_ff, phase_in;
   // division
   logic [69:0]  num_ff, num_in;
   logic [35:0]  rem_ff, rem_in;
   logic [34:0]  quo_ff, quo_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [34:0]  cand_ff, cand_in;
   rsp_type      out_ff, out_in;
   logic         out_v_ff, out_v_in;

   logic [34:0]  absc;
   logic [35:0]  rsh;
   logic [34:0]  id_ext;

   always_comb begin
      state_in = state_ff; item_in = item_ff; qx_in = qx_ff; qy_in = qy_ff;
      circle_in = circle_ff; line_in = line_ff; best_id_in = best_id_ff;
      best_d_in = best_d_ff; dx_in = dx_ff; dy_in = dy_ff; ex_in = ex_ff;
      ey_in = ey_ff; wx_in = wx_ff; wy_in = wy_ff; dsq_in = dsq_ff;
      wsq_in = wsq_ff; l2_in = l2_ff; dot_in = dot_ff; cr_in = cr_ff;
      rsq_in = rsq_ff; phase_in = phase_ff; num_in = num_ff; rem_in = rem_ff;
      quo_in = quo_ff; cnt_in = cnt_ff; cand_in = cand_ff; out_in = out_ff;
      out_v_in = out_v_ff; in_pop = 1'b0;
      absc = cr_ff[35] ? 35'(-cr_ff) : cr_ff[34:0];
      rsh = {rem_ff[34:0], num_ff[69]};
      id_ext = 35'(best_id_ff);
      if (out_v_ff && !rsp_stall) begin
         out_v_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               in_pop   = 1'b1;
               item_in  = in_data;
               dx_in = 17'(qx_ff) - 17'(in_data.first_x);
               dy_in = 17'(qy_ff) - 17'(in_data.first_y);
               ex_in = 17'(in_data.second_x) - 17'(in_data.first_x);
               ey_in = 17'(in_data.second_y) - 17'(in_data.first_y);
               wx_in = 17'(qx_ff) - 17'(in_data.second_x);
               wy_in = 17'(qy_ff) - 17'(in_data.second_y);
               phase_in = 2'd0;
               if (in_data.action == ACT_BEGIN) begin
                  qx_in = in_data.first_x;
                  qy_in = in_data.first_y;
                  circle_in = 1'b0; line_in = 1'b0;
                  best_id_in = '0; best_d_in = '1;
                  state_in = ST_UPD;
               end else if ((in_data.action == ACT_CIRCLE ||
                             in_data.action == ACT_SEGMENT) && !circle_ff) begin
                  state_in = ST_PROD;
               end else begin
                  state_in = ST_UPD;
               end
            end
         end
         ST_PROD: begin
            // products are formed in turn, one group per phase
            phase_in = phase_ff + 2'd1;
            unique case (phase_ff)
               2'd0: begin
                  dsq_in = 36'(dx_ff * dx_ff) + 36'(dy_ff * dy_ff);
                  rsq_in = 32'(item_ff.radius) * 32'(item_ff.radius);
               end
               2'd1: l2_in  = 36'(ex_ff * ex_ff) + 36'(ey_ff * ey_ff);
               2'd2: dot_in = 36'(dx_ff * ex_ff) + 36'(dy_ff * ey_ff);
               default: begin
                  wsq_in = 36'(wx_ff * wx_ff) + 36'(wy_ff * wy_ff);
                  cr_in  = 36'(dx_ff * ey_ff) - 36'(dy_ff * ex_ff);
                  state_in = ST_CLASS;
               end
            endcase
         end
         ST_CLASS: begin
            if (item_ff.action == ACT_CIRCLE) begin
               if (dsq_ff[34:0] <= 35'(rsq_ff)) begin
                  circle_in = 1'b1;
                  best_id_in = item_ff.entity_id[IdWidth-1:0];
               end
               state_in = ST_UPD;
            end else if (dot_ff <= 0) begin
               cand_in = dsq_ff[34:0];
               state_in = ST_UPD;
            end else if (dot_ff >= l2_ff) begin
               cand_in = wsq_ff[34:0];
               state_in = ST_UPD;
            end else begin
               num_in = {35'd0, absc} * {35'd0, absc};
               rem_in = '0; quo_in = '0; cnt_in = 7'd70;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            num_in = {num_ff[68:0], 1'b0};
            if (rsh >= l2_ff) begin
               rem_in = rsh - l2_ff;
               quo_in = {quo_ff[33:0], 1'b1};
            end else begin
               rem_in = rsh;
               quo_in = {quo_ff[33:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               cand_in = quo_in;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (item_ff.action == ACT_SEGMENT && !circle_ff &&
                cand_ff < best_d_ff && cand_ff < 35'(threshold)) begin
               best_d_in = cand_ff; best_id_in = item_ff.entity_id[IdWidth-1:0];
               line_in = 1'b1;
            end
            state_in = item_ff.last ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (!out_v_ff || !rsp_stall) begin
               out_v_in = 1'b1;
               if (circle_ff) begin
                  out_in.hit_kind = KIND_CIRCLE;
                  out_in.picked_id = 16'(id_ext);
                  out_in.picked_distance_sq = '0;
               end else if (line_ff) begin
                  out_in.hit_kind = KIND_LINE;
                  out_in.picked_id = 16'(id_ext);
                  out_in.picked_distance_sq = best_d_ff;
               end else begin
                  out_in = '0;
                  out_in.hit_kind = KIND_NONE;
               end
               circle_in = 1'b0; line_in = 1'b0;
               best_id_in = '0; best_d_in = '1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; qx_ff <= '0; qy_ff <= '0;
         circle_ff <= 1'b0; line_ff <= 1'b0;
         best_id_ff <= '0; best_d_ff <= '1; out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; qx_ff <= qx_in; qy_ff <= qy_in;
         circle_ff <= circle_in; line_ff <= line_in;
         best_id_ff <= best_id_in; best_d_ff <= best_d_in; out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in; dx_ff <= dx_in; dy_ff <= dy_in; ex_ff <= ex_in;
      ey_ff <= ey_in; wx_ff <= wx_in; wy_ff <= wy_in; dsq_ff <= dsq_in;
      wsq_ff <= wsq_in; l2_ff <= l2_in; dot_ff <= dot_in; cr_ff <= cr_in;
      rsq_ff <= rsq_in; phase_ff <= phase_in; num_ff <= num_in;
      rem_ff <= rem_in; quo_ff <= quo_in; cnt_ff <= cnt_in;
      cand_ff <= cand_in; out_ff <= out_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
endmodule
`default_nettype wire

>>> sv/nearest_segment_hit_test_unit.sv
// ---------------------------------------------------------------------------
// nearest_segment_hit_test_unit
// Pick query: circle hit test and nearest segment search around a click.
// ---------------------------------------------------------------------------
//  channel | ports       | payload
//  input   | req_*       | req_type (action, points, radius, id, last)
//  result  | rsp_*       | rsp_type (kind, id, distance)
//  config  | csr_*       | threshold at address 0
// Begin/skipped items go straight to update; circles and segments first run products
// and classify, interior segments also a 70-step restoring divider; last items report.
// A two-entry queue lets the input keep moving while the engine works.
// Reset is synchronous and clears state and sets threshold to 25600.
// A stalled result holds; the engine waits for it before the next report.
`default_nettype none
module nearest_segment_hit_test_unit (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  nsht_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output nsht_pkg::rsp_type  rsp_data,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [1:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import nsht_pkg::*;

   logic [31:0] thr_ff, thr_in;
   logic        full, empty, pop;
   req_type     q_data;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == {REG_THRESHOLD}) ? thr_ff : 32'd0;
   assign req_stall  = full;

   always_comb begin
      thr_in = thr_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_THRESHOLD) begin
         thr_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 32'd25600;
      end else begin
         thr_ff <= thr_in;
      end
   end

   nsht_queue u_queue (
      .clock(clock), .reset(reset),
      .push(req_valid && !full), .push_data(req_data),
      .full(full), .empty(empty), .pop(pop), .pop_data(q_data)
   );

   nsht_engine u_engine (
      .clock(clock), .reset(reset),
      .in_valid(!empty), .in_data(q_data), .in_pop(pop),
      .threshold(thr_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

>>> sv/nsht_checker.sv
// ---------------------------------------------------------------------------
// nsht_checker
// Port-level checks for the hit test unit.
// ---------------------------------------------------------------------------
`default_nettype none
`include "nearest_segment_hit_test_unit_assert.svh"
module nsht_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input nsht_pkg::rsp_type      rsp_data,
   input wire logic              csr_pready
);
   import nsht_pkg::*;

   `NSHT_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result dropped under stall")
   `NSHT_ASSERT_IMPL(a_kind, clock, reset, rsp_valid, rsp_data.hit_kind <= KIND_LINE, "bad kind")
   `NSHT_ASSERT_IMPL(a_none, clock, reset, rsp_valid && rsp_data.hit_kind == KIND_NONE, rsp_data.picked_id == '0 && rsp_data.picked_distance_sq == '0, "empty result not zero")
   `NSHT_ASSERT_IMPL(a_circ, clock, reset, rsp_valid && rsp_data.hit_kind == KIND_CIRCLE, rsp_data.picked_distance_sq == '0, "circle distance not zero")
   `NSHT_ASSERT_IMPL(a_rdy, clock, reset, 1'b1, csr_pready, "pready low")
endmodule

bind nearest_segment_hit_test_unit nsht_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_data(rsp_data), .csr_pready(csr_pready)
);
`default_nettype wire
